// ===== src/kmeans_2d_clustering_macros.svh =====
// Assertion helpers shared by the checker.
`ifndef KMEANS_2D_CLUSTERING_MACROS_SVH
`define KMEANS_2D_CLUSTERING_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KMC_ASSERT_NOW(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define KMC_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ===== src/kmc_pkg.sv =====
`default_nettype none
package kmc_pkg;
    localparam int MAX_POINTS = 1024;
    localparam int PTR_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = PTR_W + 1;
    localparam int MAX_CL     = 8;
    localparam int CL_W       = $clog2(MAX_CL);
    localparam int K_W        = CL_W + 1;
    localparam int COORD_W    = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int DIST_W     = SQ_W + 1;
    localparam int SUM_W      = COORD_W + PTR_W;
    localparam int DIVCNT_W   = $clog2(SUM_W + 1);

    localparam logic [2:0] ADDR_NUM_CLUSTERS = 3'd0;
    localparam logic [2:0] ADDR_MAX_ITER     = 3'd4;

    typedef struct packed {
        logic                     start;
        logic signed [SUM_W-1:0]  dividend;
        logic [CNT_W-1:0]         divisor;
    } t_div_req;

    typedef struct packed {
        logic                      done;
        logic signed [COORD_W-1:0] quotient;
    } t_div_rsp;
endpackage
`default_nettype wire

// ===== src/kmc_ram.sv =====
`default_nettype none
module kmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/kmc_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle, truncates toward zero.
module kmc_div (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  kmc_pkg::t_div_req i_req,
    output kmc_pkg::t_div_rsp o_rsp
);
    logic                          r_busy;
    logic [kmc_pkg::DIVCNT_W-1:0]  r_cnt;
    logic [kmc_pkg::SUM_W-1:0]     r_quo;
    logic [kmc_pkg::CNT_W-1:0]     r_rem;
    logic [kmc_pkg::CNT_W-1:0]     r_den;
    logic                          r_neg;
    logic [kmc_pkg::CNT_W:0]       w_trial;
    logic [kmc_pkg::SUM_W-1:0]     w_mag;
    logic [kmc_pkg::COORD_W-1:0]   w_q16;

    assign w_trial = {r_rem, r_quo[kmc_pkg::SUM_W-1]};
    assign w_mag   = i_req.dividend[kmc_pkg::SUM_W-1] ? kmc_pkg::SUM_W'(-i_req.dividend)
                                                      : kmc_pkg::SUM_W'(i_req.dividend);
    assign w_q16   = r_quo[kmc_pkg::COORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= kmc_pkg::DIVCNT_W'(kmc_pkg::SUM_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= w_mag;
            r_rem <= '0;
            r_den <= i_req.divisor;
            r_neg <= i_req.dividend[kmc_pkg::SUM_W-1];
        end else if (r_busy && r_cnt != '0) begin
            if (w_trial >= {1'b0, r_den}) begin
                r_rem <= kmc_pkg::CNT_W'(w_trial - {1'b0, r_den});
                r_quo <= {r_quo[kmc_pkg::SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[kmc_pkg::CNT_W-1:0];
                r_quo <= {r_quo[kmc_pkg::SUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done     = r_busy && (r_cnt == '0);
    assign o_rsp.quotient = r_neg ? -w_q16 : w_q16;
endmodule
`default_nettype wire

// ===== src/kmeans_2d_clustering.sv =====
// Lloyd k-means over signed Q8.8 2D points.
// Input stream: one point per item (s_tdata = x, y), s_tlast on the last point
// of a data set. Points load at one item per cycle into a 1024-entry point
// memory; points beyond that are dropped and flagged as overflow.
// After the last point, s_tready drops and clustering runs on one shared
// squarer and one bit-serial divider. In each round every point is read and
// waited on, then gets one squarer pass each for dx and dy and a compare per
// cluster, then an update; each nonempty cluster then gets one division each
// for x and y for its centroid update. Rounds are bounded by max_iterations.
// Results: one item per cluster on the output stream, in index order, m_tlast
// on the last; output holds while m_tready is low, and the block takes the next
// data set only after the last result is taken.
// Configuration: APB, num_clusters at 0x0, max_iterations at 0x4; write only
// while idle. Reset clears counters, flags and centroids and sets k = 2,
// max_iterations = 32; the point memory needs no clearing.
`default_nettype none
module kmeans_2d_clustering (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [31:0]  s_tdata,   // point_x[15:0], point_y[31:16]
    input  wire         s_tlast,   // last_point
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata,   // centroid_x[15:0], centroid_y[31:16],
                                   // member_count[42:32], converged[43], overflow[44]
    output logic [2:0]  m_tuser,   // cluster_index[2:0]
    output logic        m_tlast,   // last_cluster
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [2:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int CW = kmc_pkg::COORD_W;

    typedef enum logic [13:0] {
        S_LOAD    = 14'b00000000000001,
        S_INIT_RD = 14'b00000000000010,
        S_INIT_WR = 14'b00000000000100,
        S_RND     = 14'b00000000001000,
        S_P_RD    = 14'b00000000010000,
        S_P_WAIT  = 14'b00000000100000,
        S_DX      = 14'b00000001000000,
        S_DY      = 14'b00000010000000,
        S_DC      = 14'b00000100000000,
        S_P_UPD   = 14'b00001000000000,
        S_R_END   = 14'b00010000000000,
        S_DIV_X   = 14'b00100000000000,
        S_DIV_Y   = 14'b01000000000000,
        S_OUT     = 14'b10000000000000
    } t_state;

    t_state                          r_state;
    logic [3:0]                      r_nc;
    logic [7:0]                      r_mi;
    logic [kmc_pkg::CNT_W-1:0]       r_n;
    logic                            r_ovf;
    logic [kmc_pkg::K_W-1:0]         r_k;
    logic [7:0]                      r_lim;
    logic [7:0]                      r_round;
    logic [kmc_pkg::K_W-1:0]         r_c;
    logic [kmc_pkg::CNT_W-1:0]       r_i;
    logic                            r_any;
    logic                            r_conv;
    logic                            r_dbusy;
    logic signed [CW-1:0]            r_px;
    logic signed [CW-1:0]            r_py;
    logic [kmc_pkg::CL_W-1:0]        r_old;
    logic [kmc_pkg::SQ_W-1:0]        r_sq;
    logic [kmc_pkg::DIST_W-1:0]      r_dist;
    logic [kmc_pkg::DIST_W-1:0]      r_bdist;
    logic [kmc_pkg::CL_W-1:0]        r_best;
    logic signed [CW-1:0]            r_cx   [kmc_pkg::MAX_CL];
    logic signed [CW-1:0]            r_cy   [kmc_pkg::MAX_CL];
    logic signed [kmc_pkg::SUM_W-1:0] r_sx  [kmc_pkg::MAX_CL];
    logic signed [kmc_pkg::SUM_W-1:0] r_sy  [kmc_pkg::MAX_CL];
    logic [kmc_pkg::CNT_W-1:0]       r_cnt  [kmc_pkg::MAX_CL];

    logic                            w_s_acc;
    logic                            w_m_acc;
    logic                            w_cfg_wr;
    logic [kmc_pkg::K_W-1:0]         w_k;
    logic [7:0]                      w_lim;
    logic [kmc_pkg::CL_W-1:0]        w_ci;
    logic signed [kmc_pkg::DIFF_W-1:0] w_diff;
    logic signed [kmc_pkg::SQ_W-1:0] w_sq;
    logic                            w_pt_we;
    logic [kmc_pkg::PTR_W-1:0]       w_pt_raddr;
    logic [31:0]                     w_pt_rdata;
    logic                            w_as_we;
    logic [kmc_pkg::CL_W-1:0]        w_as_rdata;
    kmc_pkg::t_div_req               w_dreq;
    kmc_pkg::t_div_rsp               w_drsp;

    assign w_ci     = r_c[kmc_pkg::CL_W-1:0];
    assign s_tready = (r_state == S_LOAD);
    assign w_s_acc  = s_tvalid && s_tready;
    assign m_tvalid = (r_state == S_OUT);
    assign w_m_acc  = m_tvalid && m_tready;
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = paddr[2] ? {24'd0, r_mi} : {28'd0, r_nc};

    always_comb begin
        if (r_nc == 4'd0) begin
            w_k = kmc_pkg::K_W'(1);
        end else if (r_nc > 4'(kmc_pkg::MAX_CL)) begin
            w_k = kmc_pkg::K_W'(kmc_pkg::MAX_CL);
        end else begin
            w_k = kmc_pkg::K_W'(r_nc);
        end
        w_lim = (r_mi == 8'd0) ? 8'd1 : r_mi;
    end

    // shared squarer: dx in S_DX, dy otherwise
    assign w_diff = (r_state == S_DX)
                  ? kmc_pkg::DIFF_W'(r_px) - kmc_pkg::DIFF_W'(r_cx[w_ci])
                  : kmc_pkg::DIFF_W'(r_py) - kmc_pkg::DIFF_W'(r_cy[w_ci]);
    assign w_sq   = w_diff * w_diff;

    assign w_pt_we    = w_s_acc && (r_n < kmc_pkg::CNT_W'(kmc_pkg::MAX_POINTS));
    assign w_pt_raddr = (r_state == S_INIT_RD) ? kmc_pkg::PTR_W'(r_c)
                                               : r_i[kmc_pkg::PTR_W-1:0];
    assign w_as_we    = (r_state == S_P_UPD);

    kmc_ram #(.WIDTH(32), .DEPTH(kmc_pkg::MAX_POINTS)) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (w_pt_we),
        .i_waddr (r_n[kmc_pkg::PTR_W-1:0]),
        .i_wdata (s_tdata),
        .i_raddr (w_pt_raddr),
        .o_rdata (w_pt_rdata)
    );

    kmc_ram #(.WIDTH(kmc_pkg::CL_W), .DEPTH(kmc_pkg::MAX_POINTS)) u_as_ram (
        .i_clk   (i_clk),
        .i_we    (w_as_we),
        .i_waddr (r_i[kmc_pkg::PTR_W-1:0]),
        .i_wdata (r_best),
        .i_raddr (r_i[kmc_pkg::PTR_W-1:0]),
        .o_rdata (w_as_rdata)
    );

    always_comb begin
        w_dreq.start    = ((r_state == S_DIV_X) || (r_state == S_DIV_Y)) && !r_dbusy
                          && (r_c != r_k) && (r_cnt[w_ci] != '0);
        w_dreq.dividend = (r_state == S_DIV_Y) ? r_sy[w_ci] : r_sx[w_ci];
        w_dreq.divisor  = r_cnt[w_ci];
    end

    kmc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc <= 4'd2;
            r_mi <= 8'd32;
        end else if (w_cfg_wr) begin
            if (paddr[2]) begin
                r_mi <= pwdata[7:0];
            end else begin
                r_nc <= pwdata[3:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_n     <= '0;
            r_ovf   <= 1'b0;
            r_round <= '0;
            r_c     <= '0;
            r_i     <= '0;
            r_any   <= 1'b0;
            r_conv  <= 1'b0;
            r_dbusy <= 1'b0;
            r_k     <= '0;
            r_lim   <= '0;
            for (int c = 0; c < kmc_pkg::MAX_CL; c++) begin
                r_cx[c]  <= '0;
                r_cy[c]  <= '0;
                r_sx[c]  <= '0;
                r_sy[c]  <= '0;
                r_cnt[c] <= '0;
            end
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (w_s_acc) begin
                        if (w_pt_we) begin
                            r_n <= r_n + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (s_tlast) begin
                            r_k     <= w_k;
                            r_lim   <= w_lim;
                            r_c     <= '0;
                            r_round <= '0;
                            r_state <= S_INIT_RD;
                        end
                    end
                end
                S_INIT_RD: begin
                    r_state <= S_INIT_WR;
                end
                S_INIT_WR: begin
                    if (kmc_pkg::CNT_W'(r_c) < r_n) begin
                        r_cx[w_ci] <= w_pt_rdata[CW-1:0];
                        r_cy[w_ci] <= w_pt_rdata[2*CW-1:CW];
                    end else begin
                        r_cx[w_ci] <= '0;
                        r_cy[w_ci] <= '0;
                    end
                    if (r_c + 1'b1 == r_k) begin
                        r_state <= S_RND;
                    end else begin
                        r_c     <= r_c + 1'b1;
                        r_state <= S_INIT_RD;
                    end
                end
                S_RND: begin
                    for (int c = 0; c < kmc_pkg::MAX_CL; c++) begin
                        r_sx[c]  <= '0;
                        r_sy[c]  <= '0;
                        r_cnt[c] <= '0;
                    end
                    r_any   <= (r_round == '0);
                    r_i     <= '0;
                    r_state <= (r_n == '0) ? S_R_END : S_P_RD;
                end
                S_P_RD: begin
                    r_state <= S_P_WAIT;
                end
                S_P_WAIT: begin
                    r_px    <= w_pt_rdata[CW-1:0];
                    r_py    <= w_pt_rdata[2*CW-1:CW];
                    r_old   <= w_as_rdata;
                    r_c     <= '0;
                    r_state <= S_DX;
                end
                S_DX: begin
                    r_sq    <= w_sq;
                    r_state <= S_DY;
                end
                S_DY: begin
                    r_dist  <= kmc_pkg::DIST_W'(r_sq) + kmc_pkg::DIST_W'(unsigned'(w_sq));
                    r_state <= S_DC;
                end
                S_DC: begin
                    // lowest index wins ties: strict compare only
                    if (r_c == '0 || r_dist < r_bdist) begin
                        r_bdist <= r_dist;
                        r_best  <= w_ci;
                    end
                    if (r_c + 1'b1 == r_k) begin
                        r_state <= S_P_UPD;
                    end else begin
                        r_c     <= r_c + 1'b1;
                        r_state <= S_DX;
                    end
                end
                S_P_UPD: begin
                    if (r_round != '0 && r_old != r_best) begin
                        r_any <= 1'b1;
                    end
                    r_sx[r_best]  <= r_sx[r_best] + kmc_pkg::SUM_W'(r_px);
                    r_sy[r_best]  <= r_sy[r_best] + kmc_pkg::SUM_W'(r_py);
                    r_cnt[r_best] <= r_cnt[r_best] + 1'b1;
                    r_i           <= r_i + 1'b1;
                    r_state       <= (r_i + 1'b1 == r_n) ? S_R_END : S_P_RD;
                end
                S_R_END: begin
                    r_c <= '0;
                    if (!r_any) begin
                        r_conv  <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_conv  <= 1'b0;
                        r_state <= S_DIV_X;
                    end
                end
                S_DIV_X: begin
                    if (!r_dbusy) begin
                        if (r_c == r_k) begin
                            r_round <= r_round + 1'b1;
                            r_c     <= '0;
                            r_state <= (r_round + 1'b1 >= r_lim) ? S_OUT : S_RND;
                        end else if (r_cnt[w_ci] == '0) begin
                            r_c <= r_c + 1'b1;
                        end else begin
                            r_dbusy <= 1'b1;
                        end
                    end else if (w_drsp.done) begin
                        r_cx[w_ci] <= w_drsp.quotient;
                        r_dbusy    <= 1'b0;
                        r_state    <= S_DIV_Y;
                    end
                end
                S_DIV_Y: begin
                    if (!r_dbusy) begin
                        r_dbusy <= 1'b1;
                    end else if (w_drsp.done) begin
                        r_cy[w_ci] <= w_drsp.quotient;
                        r_dbusy    <= 1'b0;
                        r_c        <= r_c + 1'b1;
                        r_state    <= S_DIV_X;
                    end
                end
                S_OUT: begin
                    if (w_m_acc) begin
                        if (r_c + 1'b1 == r_k) begin
                            r_n     <= '0;
                            r_ovf   <= 1'b0;
                            r_round <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_c <= r_c + 1'b1;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign m_tuser = w_ci;
    assign m_tlast = (r_c + 1'b1 == r_k);
    assign m_tdata = {3'd0, r_ovf, r_conv, r_cnt[w_ci], r_cy[w_ci], r_cx[w_ci]};
endmodule
`default_nettype wire

// ===== src/kmc_checker.sv =====
`default_nettype none
`include "kmeans_2d_clustering_macros.svh"
module kmc_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire        m_tlast,
    input wire        pready
);
    `KMC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `KMC_ASSERT_NOW(a_no_load_in_out, i_clk, i_rst_n, m_tvalid, !s_tready, "input taken while results pending")
    `KMC_ASSERT_NXT(a_run_ends, i_clk, i_rst_n, m_tvalid && m_tready && m_tlast, !m_tvalid && s_tready, "no return to loading after last result")
    `KMC_ASSERT_NOW(a_pready, i_clk, i_rst_n, 1'b1, pready, "pready low")
endmodule

bind kmeans_2d_clustering kmc_checker u_kmc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .pready   (pready)
);
`default_nettype wire

// ===== tb/kmeans_2d_clustering_tb.sv =====
`default_nettype none
module kmeans_2d_clustering_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]         index;
        logic signed [15:0] cent_x;
        logic signed [15:0] cent_y;
        logic [10:0]        members;
        logic               conv;
        logic               ovf;
        logic               last;
    } t_cluster_rpt;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic s_tvalid, s_tlast, m_tready;
    logic [31:0] s_tdata;
    logic s_tready, m_tvalid, m_tlast, pready;
    logic [47:0] m_tdata;
    logic [2:0] m_tuser;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;

    kmeans_2d_clustering DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    int unsigned k_reg = 2, iter_reg = 32;
    longint pt_x[kmc_pkg::MAX_POINTS], pt_y[kmc_pkg::MAX_POINTS];
    int unsigned member_of[kmc_pkg::MAX_POINTS];
    longint cen_x[kmc_pkg::MAX_CL], cen_y[kmc_pkg::MAX_CL];
    int unsigned npts = 0;
    bit dropped = 0;
    t_cluster_rpt pending_rpts[$];

    int errors = 0;
    int send_idle = 0, recv_idle = 0;

    task automatic cluster_points();
        int unsigned k, lim, rounds, best;
        longint sx[kmc_pkg::MAX_CL], sy[kmc_pkg::MAX_CL];
        int unsigned cnt[kmc_pkg::MAX_CL];
        longint dx, dy, d, bd;
        bit moved;
        t_cluster_rpt r;
        k = (k_reg < 1) ? 1 : (k_reg > kmc_pkg::MAX_CL) ? kmc_pkg::MAX_CL : k_reg;
        lim = (iter_reg < 1) ? 1 : iter_reg;
        for (int c = 0; c < k; c++) begin
            cen_x[c] = (c < npts) ? pt_x[c] : 0;
            cen_y[c] = (c < npts) ? pt_y[c] : 0;
        end
        rounds = 0;
        forever begin
            moved = (rounds == 0);
            for (int c = 0; c < k; c++) begin
                sx[c] = 0; sy[c] = 0; cnt[c] = 0;
            end
            for (int i = 0; i < npts; i++) begin
                best = 0;
                bd = 0;
                for (int c = 0; c < k; c++) begin
                    dx = pt_x[i] - cen_x[c];
                    dy = pt_y[i] - cen_y[c];
                    d = dx * dx + dy * dy;
                    if (c == 0 || d < bd) begin
                        best = c;
                        bd = d;
                    end
                end
                if (rounds != 0 && member_of[i] != best) moved = 1;
                member_of[i] = best;
                sx[best] += pt_x[i];
                sy[best] += pt_y[i];
                cnt[best]++;
            end
            if (!moved) break;
            for (int c = 0; c < k; c++) begin
                if (cnt[c] != 0) begin
                    cen_x[c] = sx[c] / longint'(cnt[c]);
                    cen_y[c] = sy[c] / longint'(cnt[c]);
                end
            end
            rounds++;
            if (rounds >= lim) break;
        end
        for (int c = 0; c < k; c++) begin
            r.index = 3'(c);
            r.cent_x = 16'(cen_x[c]);
            r.cent_y = 16'(cen_y[c]);
            r.members = 11'(cnt[c]);
            r.conv = !moved;
            r.ovf = dropped;
            r.last = (c + 1 == k);
            pending_rpts.insert(pending_rpts.size(), r);
        end
        npts = 0;
        dropped = 0;
    endtask

    task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, bit last);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {y, x};
        s_tlast <= last;
        do @(posedge i_clk); while (!s_tready);
        if (npts < kmc_pkg::MAX_POINTS) begin
            pt_x[npts] = x;
            pt_y[npts] = y;
            npts++;
        end else begin
            dropped = 1;
        end
        if (last) cluster_points();
    endtask

    // hold off until the block has drained its results
    task automatic wait_idle();
        @(posedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_rpts.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // setup and access cycles; the caller releases the bus
    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == kmc_pkg::ADDR_NUM_CLUSTERS) k_reg = data & 32'hF;
        else iter_reg = data & 32'hFF;
    endtask

    task automatic set_config(int unsigned k, int unsigned iters);
        wait_idle();
        write_reg(kmc_pkg::ADDR_NUM_CLUSTERS, k);
        write_reg(kmc_pkg::ADDR_MAX_ITER, iters);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_set(int unsigned n, bit noise);
        logic signed [15:0] hx[8], hy[8];
        int unsigned h;
        for (int c = 0; c < 8; c++) begin
            hx[c] = 16'($urandom);
            hy[c] = 16'($urandom);
        end
        for (int i = 0; i < n; i++) begin
            h = $urandom_range(7);
            if (noise) send_point(16'($urandom), 16'($urandom), i == n - 1);
            else send_point(hx[h] + $signed(10'($urandom)), hy[h] + $signed(10'($urandom)),
                            i == n - 1);
        end
    endtask

    task automatic test_directed();
        set_config(2, 32);
        send_point(16'sh8000, 16'sh8000, 1'b0);
        send_point(16'sh7fff, 16'sh7fff, 1'b0);
        send_point(16'sh8000, 16'sh7fff, 1'b0);
        send_point(16'sh7fff, 16'sh8000, 1'b1);
        // equal distances: lowest index wins
        send_point(-16'sd100, 16'sd0, 1'b0);
        send_point(16'sd100, 16'sd0, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b1);
        // fewer points than clusters
        set_config(8, 255);
        send_point(16'sd5, -16'sd7, 1'b0);
        send_point(16'sd300, 16'sd1, 1'b0);
        send_point(16'sd300, 16'sd1, 1'b1);
        // cluster count zero, single point
        set_config(0, 0);
        send_point(16'sh1234, 16'shedcb, 1'b1);
        // cluster count above range, one round
        set_config(15, 1);
        send_set(10, 0);
        set_config(3, 2);
        send_set(6, 0);
    endtask

    task automatic test_overflow();
        set_config(1, 1);
        send_set(kmc_pkg::MAX_POINTS + 4, 1);
        wait_idle();
        send_set(3, 0);
    endtask

    task automatic test_random(int unsigned n_items);
        int unsigned sent = 0, n;
        while (sent < n_items) begin
            if ($urandom_range(2) == 0)
                set_config($urandom_range(15),
                           $urandom_range(9) == 0 ? $urandom_range(1) * 255
                                                  : $urandom_range(1, 40));
            if ($urandom_range(5) == 0) wait_idle();
            n = $urandom_range(1, 14);
            send_set(n, $urandom_range(4) == 0);
            sent += n;
        end
    endtask

    always @(posedge i_clk) begin
        t_cluster_rpt got, want;
        m_tready <= ($urandom_range(99) >= recv_idle);
        if (i_rst_n && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[42:32],
                   m_tdata[43], m_tdata[44], m_tlast};
            if (pending_rpts.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected cluster result idx=%0d", got.index);
            end else begin
                want = pending_rpts.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch exp idx=%0d x=%0d y=%0d n=%0d c=%b o=%b l=%b",
                                  " | got idx=%0d x=%0d y=%0d n=%0d c=%b o=%b l=%b"},
                            want.index, want.cent_x, want.cent_y, want.members, want.conv,
                            want.ovf, want.last, got.index, got.cent_x, got.cent_y,
                            got.members, got.conv, got.ovf, got.last);
                end
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        s_tvalid <= 1'b0; s_tdata <= '0; s_tlast <= 1'b0; m_tready <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_overflow();
        send_idle = 30; recv_idle = 48;
        test_random(35);
        send_idle = 48; recv_idle = 30;
        test_random(35);
        send_idle = 0; recv_idle = 0;
        test_random(35);
        wait_idle();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending_rpts.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== kmeans_2d_clustering.f =====
+incdir+src
src/kmc_pkg.sv
src/kmc_ram.sv
src/kmc_div.sv
src/kmeans_2d_clustering.sv
src/kmc_checker.sv
tb/kmeans_2d_clustering_tb.sv
